### rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MUL_P = 2'd0,
        MUL_Q = 2'd1,
        MUL_D = 2'd2
    } t_mul_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_Q,
        ST_MUL_D,
        ST_COMB,
        ST_GCD,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     combine;
        logic     gcd_step;
        logic     div_init;
        logic     div_step;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic gcd_done;
        logic div_one;
        logic div_last;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/rau_ctrl.sv
// Sequencing state machine of the rational arithmetic unit.
// Depends on rau_pkg for the state, command and status types.
`default_nettype none

module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MUL_P;
                end
            end
            ST_MUL_P: n_state = ST_MUL_Q;
            ST_MUL_Q: n_state = ST_MUL_D;
            ST_MUL_D: n_state = ST_COMB;
            ST_COMB:  n_state = ST_GCD;
            ST_GCD: begin
                if (i_sts.skip) begin
                    n_state = ST_DONE;
                end else if (i_sts.gcd_done) begin
                    n_state = i_sts.div_one ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_MUL_P: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P;
            end
            ST_MUL_Q: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_Q;
            end
            ST_MUL_D: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_D;
            end
            ST_COMB: o_cmd.combine = 1'b1;
            ST_GCD: begin
                if (!i_sts.skip) begin
                    if (i_sts.gcd_done) begin
                        o_cmd.div_init = 1'b1;
                    end else begin
                        o_cmd.gcd_step = 1'b1;
                    end
                end
            end
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_DONE: o_cmd.out_load = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/rau_datapath.sv
// Datapath of the rational arithmetic unit: operand registers, shared multiplier,
// binary GCD engine, two-lane serial divider and output register. Depends on rau_pkg.
`default_nettype none

module rau_datapath
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_dp_cmd                    i_cmd,
    output t_dp_sts                         o_sts,
    input  wire t_kind                      i_kind,
    input  wire logic [OPERAND_WIDTH-1:0]   i_first_num,
    input  wire logic [OPERAND_WIDTH-1:0]   i_first_den,
    input  wire logic [OPERAND_WIDTH-1:0]   i_second_num,
    input  wire logic [OPERAND_WIDTH-1:0]   i_second_den,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic [2*OPERAND_WIDTH:0]        o_result_num,
    output logic [2*OPERAND_WIDTH-1:0]      o_result_den,
    output logic                            o_div_by_zero
);

    localparam int W     = OPERAND_WIDTH;
    localparam int NW    = 2 * OPERAND_WIDTH;
    localparam int CNT_W = $clog2(NW);

    t_kind           r_kind,  n_kind;
    logic            r_an,    n_an;
    logic            r_cn,    n_cn;
    logic [W-1:0]    r_amag,  n_amag;
    logic [W-1:0]    r_bden,  n_bden;
    logic [W-1:0]    r_cmag,  n_cmag;
    logic [W-1:0]    r_dden,  n_dden;
    logic [NW-1:0]   r_p,     n_p;
    logic [NW-1:0]   r_q,     n_q;
    logic [NW-1:0]   r_den,   n_den;
    logic [NW-1:0]   r_a,     n_a;
    logic [NW-1:0]   r_b,     n_b;
    logic [NW-1:0]   r_n0,    n_n0;
    logic [NW-1:0]   r_d0,    n_d0;
    logic            r_neg,   n_neg;
    logic            r_err,   n_err;
    logic            r_skip,  n_skip;
    logic [NW-1:0]   r_qn,    n_qn;
    logic [NW-1:0]   r_qd,    n_qd;
    logic [NW-1:0]   r_rn,    n_rn;
    logic [NW-1:0]   r_rd,    n_rd;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic            r_out_valid, n_out_valid;
    logic [NW:0]     r_out_num,   n_out_num;
    logic [NW-1:0]   r_out_den,   n_out_den;
    logic            r_out_err,   n_out_err;

    logic [W-1:0]  in_amag;
    logic [W-1:0]  in_cmag;
    logic [W-1:0]  mul_a;
    logic [W-1:0]  mul_b;
    logic [NW-1:0] product;
    logic          q_neg;
    logic [NW-1:0] comb_mag;
    logic          comb_neg;
    logic [NW:0]   rn_sh;
    logic [NW:0]   rd_sh;
    logic [NW:0]   div_ext;
    logic          rn_ge;
    logic          rd_ge;
    logic [NW:0]   rn_nx;
    logic [NW:0]   rd_nx;

    assign in_amag = i_first_num[W-1]  ? (~i_first_num + W'(1))  : i_first_num;
    assign in_cmag = i_second_num[W-1] ? (~i_second_num + W'(1)) : i_second_num;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_P: begin
                mul_a = r_amag;
                mul_b = (r_kind == KIND_MUL) ? r_cmag : r_dden;
            end
            MUL_Q: begin
                mul_a = r_bden;
                mul_b = r_cmag;
            end
            MUL_D: begin
                mul_a = r_bden;
                mul_b = (r_kind == KIND_DIV) ? r_cmag : r_dden;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = NW'(mul_a) * NW'(mul_b);

    assign q_neg = (r_kind == KIND_SUB) ? !r_cn : r_cn;

    always_comb begin
        case (r_kind) inside
            KIND_ADD, KIND_SUB: begin
                if (r_an == q_neg) begin
                    comb_mag = r_p + r_q;
                    comb_neg = r_an;
                end else if (r_p >= r_q) begin
                    comb_mag = r_p - r_q;
                    comb_neg = r_an;
                end else begin
                    comb_mag = r_q - r_p;
                    comb_neg = q_neg;
                end
            end
            default: begin
                comb_mag = r_p;
                comb_neg = r_an ^ r_cn;
            end
        endcase
    end

    assign div_ext = {1'b0, r_a};
    assign rn_sh   = {r_rn, r_qn[NW-1]};
    assign rd_sh   = {r_rd, r_qd[NW-1]};
    assign rn_ge   = rn_sh >= div_ext;
    assign rd_ge   = rd_sh >= div_ext;
    assign rn_nx   = rn_ge ? (rn_sh - div_ext) : rn_sh;
    assign rd_nx   = rd_ge ? (rd_sh - div_ext) : rd_sh;

    always_comb begin
        n_kind      = r_kind;
        n_an        = r_an;
        n_cn        = r_cn;
        n_amag      = r_amag;
        n_bden      = r_bden;
        n_cmag      = r_cmag;
        n_dden      = r_dden;
        n_p         = r_p;
        n_q         = r_q;
        n_den       = r_den;
        n_a         = r_a;
        n_b         = r_b;
        n_n0        = r_n0;
        n_d0        = r_d0;
        n_neg       = r_neg;
        n_err       = r_err;
        n_skip      = r_skip;
        n_qn        = r_qn;
        n_qd        = r_qd;
        n_rn        = r_rn;
        n_rd        = r_rd;
        n_cnt       = r_cnt;
        n_out_num   = r_out_num;
        n_out_den   = r_out_den;
        n_out_err   = r_out_err;
        n_out_valid = i_out_ready ? 1'b0 : r_out_valid;

        if (i_cmd.load_in) begin
            n_kind = i_kind;
            n_an   = i_first_num[W-1];
            n_cn   = i_second_num[W-1];
            n_amag = in_amag;
            n_bden = i_first_den;
            n_cmag = in_cmag;
            n_dden = i_second_den;
        end

        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                MUL_P:   n_p   = product;
                MUL_Q:   n_q   = product;
                MUL_D:   n_den = product;
                default: n_p   = r_p;
            endcase
        end

        if (i_cmd.combine) begin
            n_a    = comb_mag;
            n_b    = r_den;
            n_n0   = comb_mag;
            n_d0   = r_den;
            n_neg  = comb_neg;
            n_err  = (r_den == '0);
            n_skip = (r_den == '0) || (comb_mag == '0);
        end

        if (i_cmd.gcd_step) begin
            if (!r_a[0] && !r_b[0]) begin
                n_a  = r_a >> 1;
                n_b  = r_b >> 1;
                n_n0 = r_n0 >> 1;
                n_d0 = r_d0 >> 1;
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (r_a >= r_b) begin
                n_a = r_a - r_b;
            end else begin
                n_b = r_b - r_a;
            end
        end

        if (i_cmd.div_init) begin
            n_qn  = r_n0;
            n_qd  = r_d0;
            n_rn  = '0;
            n_rd  = '0;
            n_cnt = '0;
        end

        if (i_cmd.div_step) begin
            n_qn  = {r_qn[NW-2:0], rn_ge};
            n_qd  = {r_qd[NW-2:0], rd_ge};
            n_rn  = rn_nx[NW-1:0];
            n_rd  = rd_nx[NW-1:0];
            n_cnt = r_cnt + CNT_W'(1);
        end

        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
            n_out_err   = r_err;
            if (r_skip) begin
                n_out_num = '0;
                n_out_den = NW'(1);
            end else begin
                n_out_num = r_neg ? ((NW+1)'(0) - {1'b0, r_qn}) : {1'b0, r_qn};
                n_out_den = r_qd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_an      <= n_an;
        r_cn      <= n_cn;
        r_amag    <= n_amag;
        r_bden    <= n_bden;
        r_cmag    <= n_cmag;
        r_dden    <= n_dden;
        r_p       <= n_p;
        r_q       <= n_q;
        r_den     <= n_den;
        r_a       <= n_a;
        r_b       <= n_b;
        r_n0      <= n_n0;
        r_d0      <= n_d0;
        r_neg     <= n_neg;
        r_err     <= n_err;
        r_skip    <= n_skip;
        r_qn      <= n_qn;
        r_qd      <= n_qd;
        r_rn      <= n_rn;
        r_rd      <= n_rd;
        r_cnt     <= n_cnt;
        r_out_num <= n_out_num;
        r_out_den <= n_out_den;
        r_out_err <= n_out_err;
    end

    assign o_sts.skip     = r_skip;
    assign o_sts.gcd_done = (r_a == r_b);
    assign o_sts.div_one  = (r_a == NW'(1));
    assign o_sts.div_last = (r_cnt == CNT_W'(NW - 1));
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_result_num  = r_out_num;
    assign o_result_den  = r_out_den;
    assign o_div_by_zero = r_out_err;

endmodule

`default_nettype wire

### rtl/rational_arith_unit_core.sv
// Top level of the rational arithmetic unit: stream ports, controller and datapath.
// Depends on rau_pkg, rau_ctrl and rau_datapath.
`default_nettype none

// Adds, subtracts, multiplies or divides two fractions and returns the result in lowest
// terms with the sign on the numerator; a zero result is 0/1, and a zero result
// denominator (such as a divide by a zero numerator) gives 0/1 with div_by_zero set.
// One item is worked on at a time, and s_axis_tready is high only while the block is idle.
// An item goes through the accept, three passes through the shared multiplier, the sign
// and magnitude combine, the binary GCD iterations (data dependent) and final GCD check,
// the bit-serial divider when the odd part of the GCD is not 1, and the output load.
// Zero or error results skip the GCD iterations and the divider, and the output load
// also waits while the previous result is still held.
// A finished result waits in the output register while the next item is already being taken.

module rational_arith_unit_core
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    localparam int IN_TDATA_W  = ((4 * OPERAND_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((4 * OPERAND_WIDTH + 1 + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // first_num, first_den, second_num, second_den, zero fill
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  wire logic [1:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // result_num, result_den, zero fill
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // div_by_zero
    output logic [0:0]                  m_axis_tuser
);

    localparam int W  = OPERAND_WIDTH;
    localparam int NW = 2 * OPERAND_WIDTH;

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [NW:0]   result_num;
    logic [NW-1:0] result_den;
    logic          div_by_zero;

    rau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rau_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_kind        (t_kind'(s_axis_tuser)),
        .i_first_num   (s_axis_tdata[W-1:0]),
        .i_first_den   (s_axis_tdata[2*W-1:W]),
        .i_second_num  (s_axis_tdata[3*W-1:2*W]),
        .i_second_den  (s_axis_tdata[4*W-1:3*W]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_result_num  (result_num),
        .o_result_den  (result_den),
        .o_div_by_zero (div_by_zero)
    );

    assign m_axis_tdata = OUT_TDATA_W'({result_den, result_num});
    assign m_axis_tuser = div_by_zero;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("result loaded over a result still waiting");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (result_den != '0))
        else $error("result denominator is zero");

    a_err_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && div_by_zero) |-> (result_num == '0 && result_den == NW'(1)))
        else $error("error result is not 0/1");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("new item taken while one is in work");

endmodule

`default_nettype wire

### tb/sv/rational_arith_unit_core_tb.sv
// Self-checking testbench for rational_arith_unit_core: drives fraction items with random
// gaps, predicts each reduced result and compares it with what the block returns.
// Depends on rau_pkg and the rational_arith_unit_core RTL.
`default_nettype none

module rational_arith_unit_core_tb;
    import rau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W      = OPERAND_WIDTH_DEF;
    localparam int NUM_W  = 2 * W + 1;
    localparam int DEN_W  = 2 * W;
    localparam int IN_W   = ((4 * W + 7) / 8) * 8;
    localparam int OUT_W  = ((4 * W + 1 + 7) / 8) * 8;
    localparam int N_RANDOM    = 1500;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        t_kind        kind;
        logic [W-1:0] a_num;
        logic [W-1:0] a_den;
        logic [W-1:0] b_num;
        logic [W-1:0] b_den;
        bit           drain;
        bit           burst;
    } t_frac_op;

    typedef struct {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             dbz;
    } t_frac_res;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic [1:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [0:0]       m_tuser;

    t_frac_op  pending_ops[$];
    t_frac_res expected_fracs[$];
    t_frac_op  in_flight;
    int        send_gap = 0;
    int        stall_left = 0;
    bit        stall_quiet = 1'b0;
    int        errors = 0;
    int        cycle_count = 0;

    rational_arith_unit_core #(.OPERAND_WIDTH(W)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic [63:0] magnitude(logic [W-1:0] v);
        return v[W-1] ? ((64'd1 << W) - 64'(v)) : 64'(v);
    endfunction

    function automatic t_frac_res reduced_result(t_frac_op op);
        t_frac_res   r;
        logic [63:0] amag, bden, cmag, dden, p, q, nmag, den, g;
        bit          an, cn, pn, qn, nneg, err;
        amag = magnitude(op.a_num);
        an   = op.a_num[W-1];
        cmag = magnitude(op.b_num);
        cn   = op.b_num[W-1];
        bden = 64'(op.a_den);
        dden = 64'(op.b_den);
        nmag = 0;
        den  = 0;
        nneg = 1'b0;
        err  = 1'b0;
        case (op.kind)
            KIND_ADD, KIND_SUB: begin
                p  = amag * dden;
                q  = bden * cmag;
                pn = an;
                qn = (op.kind == KIND_SUB) ? !cn : cn;
                if (pn == qn) begin
                    nmag = p + q;
                    nneg = pn;
                end else if (p >= q) begin
                    nmag = p - q;
                    nneg = pn;
                end else begin
                    nmag = q - p;
                    nneg = qn;
                end
                den = bden * dden;
            end
            KIND_MUL: begin
                nmag = amag * cmag;
                nneg = an != cn;
                den  = bden * dden;
            end
            default: begin
                if (cmag == 0) begin
                    err = 1'b1;
                end else begin
                    nmag = amag * dden;
                    nneg = an != cn;
                    den  = bden * cmag;
                end
            end
        endcase
        if (den == 0) err = 1'b1;
        if (err || nmag == 0) begin
            nmag = 0;
            nneg = 1'b0;
            den  = 1;
        end else begin
            g    = gcd64(nmag, den);
            nmag = nmag / g;
            den  = den / g;
        end
        r.num = NUM_W'(nneg ? (64'd0 - nmag) : nmag);
        r.den = DEN_W'(den);
        r.dbz = err;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    function automatic logic [W-1:0] rand_num();
        case ($urandom_range(0, 19))
            0: return {1'b1, {(W-1){1'b0}}};
            1: return {1'b0, {(W-1){1'b1}}};
            2: return '0;
            3: return W'(1);
            4: return '1;
            5, 6, 7: return W'($urandom_range(0, 32)) - W'(16);
            default: return W'($urandom);
        endcase
    endfunction

    function automatic logic [W-1:0] rand_den();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return '0;
        if (r < 8) return W'(1);
        if (r < 13) return '1;
        if (r < 35) return W'($urandom_range(1, 24));
        return W'($urandom_range(1, (1 << W) - 1));
    endfunction

    task automatic add_op(t_kind kind, logic [W-1:0] an, logic [W-1:0] ad,
                          logic [W-1:0] bn, logic [W-1:0] bd, bit drain = 1'b0);
        t_frac_op op;
        op.kind  = kind;
        op.a_num = an;
        op.a_den = ad;
        op.b_num = bn;
        op.b_den = bd;
        op.drain = drain;
        op.burst = 1'b0;
        pending_ops.push_back(op);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Driver: one item at a time from pending_ops, with a random gap after each item outside burst mode.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) expected_fracs.push_back(reduced_result(in_flight));
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap != 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_ops.size() != 0 && pending_ops[0].drain &&
                             expected_fracs.size() != 0) begin
                    s_tvalid <= 1'b0;
                end else if (pending_ops.size() != 0) begin
                    in_flight = pending_ops.pop_front();
                    s_tdata  <= IN_W'({in_flight.b_den, in_flight.b_num,
                                       in_flight.a_den, in_flight.a_num});
                    s_tuser  <= in_flight.kind;
                    s_tvalid <= 1'b1;
                    send_gap <= in_flight.burst ? 0 : idle_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result item against the oldest prediction.
    always @(posedge i_clk) begin
        t_frac_res got;
        t_frac_res want;
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.num = m_tdata[NUM_W-1:0];
                got.den = m_tdata[NUM_W +: DEN_W];
                got.dbz = m_tuser[0];
                if (expected_fracs.size() == 0) begin
                    $display("%0t: unexpected result num=%0d den=%0d dbz=%0b", $realtime,
                             $signed(got.num), got.den, got.dbz);
                    errors++;
                end else begin
                    want = expected_fracs.pop_front();
                    if (got.num !== want.num || got.den !== want.den ||
                        got.dbz !== want.dbz) begin
                        $display("%0t: mismatch expected %0d/%0d dbz=%0b, got %0d/%0d dbz=%0b",
                                 $realtime, $signed(want.num), want.den, want.dbz,
                                 $signed(got.num), got.den, got.dbz);
                        errors++;
                    end
                end
                if ($urandom_range(0, 39) == 0) stall_quiet = !stall_quiet;
            end
            if (stall_left != 0) begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_tready <= 1'b1;
                if (!stall_quiet && $urandom_range(0, 3) == 0) stall_left <= idle_len();
            end
        end
    end

    initial begin
        t_frac_op op;
        bit       burst_mode;
        logic [W-1:0] most_neg, most_pos, max_den;
        most_neg   = {1'b1, {(W-1){1'b0}}};
        most_pos   = {1'b0, {(W-1){1'b1}}};
        max_den    = '1;
        burst_mode = 1'b0;

        add_op(KIND_ADD, most_neg, W'(1), most_neg, W'(1));
        add_op(KIND_ADD, most_pos, max_den, most_pos, max_den);
        add_op(KIND_ADD, W'(1), W'(2), -W'(1), W'(2));
        add_op(KIND_SUB, most_neg, max_den, most_pos, W'(1));
        add_op(KIND_SUB, W'(7), W'(3), W'(7), W'(3));
        add_op(KIND_SUB, -W'(3), W'(4), -W'(5), W'(6));
        add_op(KIND_MUL, most_neg, W'(1), most_neg, W'(1));
        add_op(KIND_MUL, most_neg, max_den, most_pos, max_den);
        add_op(KIND_MUL, W'(0), W'(5), -W'(9), W'(7));
        add_op(KIND_MUL, W'(6), W'(35), W'(14), W'(15));
        add_op(KIND_DIV, W'(3), W'(4), W'(0), W'(5));
        add_op(KIND_DIV, most_neg, W'(1), W'(0), max_den);
        add_op(KIND_DIV, most_neg, max_den, W'(1), W'(1));
        add_op(KIND_DIV, most_pos, W'(1), -W'(1), max_den);
        add_op(KIND_DIV, W'(0), W'(3), W'(2), W'(5));
        add_op(KIND_ADD, W'(5), W'(0), W'(3), W'(4));
        add_op(KIND_SUB, W'(0), W'(0), W'(0), W'(0));
        add_op(KIND_MUL, W'(2), W'(3), W'(4), W'(0));
        add_op(KIND_DIV, W'(2), W'(0), W'(4), W'(3));
        add_op(KIND_DIV, W'(2), W'(3), W'(4), W'(0), 1'b1);
        add_op(KIND_ADD, W'(1), W'(1), W'(1), W'(1));
        add_op(KIND_MUL, '1, max_den, '1, max_den);

        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 49) == 0) burst_mode = !burst_mode;
            op.kind  = t_kind'($urandom_range(0, 3));
            op.a_num = rand_num();
            op.a_den = rand_den();
            op.b_num = rand_num();
            op.b_den = rand_den();
            op.drain = $urandom_range(0, 299) == 0;
            op.burst = burst_mode;
            pending_ops.push_back(op);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_tvalid || expected_fracs.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
